// ===== sv/crm_pkg.sv =====
// crm_pkg: shared constants and state types for the counter pair rate meter
// used by crm_rate_unit, counter_pair_rate_meter_top and crm_checker
// no dependencies

package crm_pkg;

    // ticks of the capture timestamp in one second (100 ns ticks)
    localparam int TICKS_PER_SECOND = 10000000;
    // saturation width of a computed rate
    localparam int RATE_WIDTH       = 48;

    // fixed field widths
    localparam int CNT_W   = 64;
    localparam int FIELD_W = 48;
    localparam int HALF_W  = CNT_W / 2;

    // derived datapath widths
    localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
    localparam int PROD_W = HALF_W + TPS_W;
    localparam int NUM_W  = CNT_W + TPS_W;
    localparam int HI_W   = NUM_W - RATE_WIDTH;
    localparam int REM_W  = (HI_W > CNT_W + 1) ? HI_W : CNT_W + 1;
    localparam int QCNT_W = $clog2(RATE_WIDTH);

    localparam logic [TPS_W-1:0] TPS_C = TPS_W'(TICKS_PER_SECOND);

    // reset value of the interval limit register
    localparam logic [CNT_W-1:0] MAX_INTERVAL_RESET = 64'd100000000;

    // top level sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_EL,
        S_DF,
        S_DS,
        S_LIM,
        S_R1_GO,
        S_R1_WAIT,
        S_R2_GO,
        S_R2_WAIT,
        S_DONE
    } t_state;

    // rate unit sequencer
    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL_LO,
        U_MUL_HI,
        U_ADD,
        U_CHECK,
        U_DIV,
        U_DONE
    } t_div_state;

endpackage

// ===== sv/crm_rate_unit.sv =====
// crm_rate_unit: floor(delta * TICKS_PER_SECOND / den), saturated to RATE_WIDTH bits
// one shared half-width multiplier, then a one-bit-per-cycle restoring divider
// depends on crm_pkg

module crm_rate_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [crm_pkg::CNT_W-1:0]   i_delta,
    input  logic [crm_pkg::CNT_W-1:0]   i_den,
    output logic                        o_done,
    output logic [crm_pkg::FIELD_W-1:0] o_rate
);

    crm_pkg::t_div_state r_state, n_state;

    logic [crm_pkg::PROD_W-1:0]     r_prod;
    logic [crm_pkg::NUM_W-1:0]      r_num;
    logic [crm_pkg::REM_W-1:0]      r_rem;
    logic [crm_pkg::RATE_WIDTH-1:0] r_qn;
    logic [crm_pkg::QCNT_W-1:0]     r_cnt;
    logic                           r_sat;

    logic [crm_pkg::HALF_W-1:0]     mul_a;
    logic [crm_pkg::PROD_W-1:0]     mul_p;
    logic [crm_pkg::HI_W-1:0]       num_hi;
    logic                           hi_ge;
    logic [crm_pkg::REM_W-1:0]      den_ext;
    logic [crm_pkg::REM_W-1:0]      rem_sh;
    logic                           rem_ge;
    logic [crm_pkg::RATE_WIDTH-1:0] rate_full;
    logic [crm_pkg::CNT_W-1:0]      rate_ext;

    // shared multiplier: low half of delta first, then the high half
    assign mul_a = (r_state == crm_pkg::U_MUL_HI) ? i_delta[crm_pkg::CNT_W-1:crm_pkg::HALF_W]
                                                  : i_delta[crm_pkg::HALF_W-1:0];
    assign mul_p = crm_pkg::PROD_W'(mul_a) * crm_pkg::PROD_W'(crm_pkg::TPS_C);

    // quotient overflows the rate width when the upper numerator bits reach den
    assign den_ext = crm_pkg::REM_W'(i_den);
    assign num_hi  = r_num[crm_pkg::NUM_W-1 -: crm_pkg::HI_W];
    assign hi_ge   = crm_pkg::REM_W'(num_hi) >= den_ext;

    // one restoring division step
    assign rem_sh = {r_rem[crm_pkg::REM_W-2:0], r_qn[crm_pkg::RATE_WIDTH-1]};
    assign rem_ge = rem_sh >= den_ext;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crm_pkg::U_IDLE:   if (i_start) n_state = crm_pkg::U_MUL_LO;
            crm_pkg::U_MUL_LO: n_state = crm_pkg::U_MUL_HI;
            crm_pkg::U_MUL_HI: n_state = crm_pkg::U_ADD;
            crm_pkg::U_ADD:    n_state = crm_pkg::U_CHECK;
            crm_pkg::U_CHECK:  n_state = hi_ge ? crm_pkg::U_DONE : crm_pkg::U_DIV;
            crm_pkg::U_DIV:    if (r_cnt == '0) n_state = crm_pkg::U_DONE;
            crm_pkg::U_DONE:   n_state = crm_pkg::U_IDLE;
            default:           n_state = crm_pkg::U_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_done = 1'b0;
        unique case (r_state)
            crm_pkg::U_DONE: o_done = 1'b1;
            default:         o_done = 1'b0;
        endcase
    end

    assign rate_full = r_sat ? '1 : r_qn;
    assign rate_ext  = crm_pkg::CNT_W'(rate_full);
    assign o_rate    = rate_ext[crm_pkg::FIELD_W-1:0];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crm_pkg::U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            crm_pkg::U_MUL_LO: begin
                r_prod <= mul_p;
            end
            crm_pkg::U_MUL_HI: begin
                r_num  <= crm_pkg::NUM_W'(r_prod);
                r_prod <= mul_p;
            end
            crm_pkg::U_ADD: begin
                r_num <= r_num + (crm_pkg::NUM_W'(r_prod) << crm_pkg::HALF_W);
            end
            crm_pkg::U_CHECK: begin
                r_sat <= hi_ge;
                r_rem <= crm_pkg::REM_W'(num_hi);
                r_qn  <= r_num[crm_pkg::RATE_WIDTH-1:0];
                r_cnt <= crm_pkg::QCNT_W'(crm_pkg::RATE_WIDTH - 1);
            end
            crm_pkg::U_DIV: begin
                r_rem <= rem_ge ? rem_sh - den_ext : rem_sh;
                r_qn  <= {r_qn[crm_pkg::RATE_WIDTH-2:0], rem_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== sv/counter_pair_rate_meter_top.sv =====
// counter_pair_rate_meter_top: byte-rate meter for two channels from counter snapshots
// holds the previous snapshot per channel, checks it and runs crm_rate_unit twice when a rate is formed
// depends on crm_pkg and crm_rate_unit
//
//   channel  direction  handshake                      payload
//   in       receive    i_in_valid / o_in_stall        kind, available, counters, time, id
//   out      send       o_out_valid / i_out_stall      channel, flags, two rates
//   cfg      receive    i_cfg_we                       max_interval_ticks
//
// a request runs the four checks on the shared 64 bit subtractor and, when a rate is
// formed, the one-bit-per-cycle divider twice; a saturated rate skips its 48 divide steps.
// the input stalls while a request is in work and accepts again in the cycle after the
// result is loaded. a finished result sits in the output register, so a stalled output
// only holds the block when the next result is ready. synchronous active low reset, no
// clearing pass.

module counter_pair_rate_meter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [crm_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_kind,
    input  logic                        i_available,
    input  logic [crm_pkg::CNT_W-1:0]   i_first_count,
    input  logic [crm_pkg::CNT_W-1:0]   i_second_count,
    input  logic [crm_pkg::CNT_W-1:0]   i_capture_time,
    input  logic [crm_pkg::CNT_W-1:0]   i_source_id,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_channel,
    output logic                        o_needs_baseline,
    output logic                        o_rate_valid,
    output logic [crm_pkg::FIELD_W-1:0] o_first_rate,
    output logic [crm_pkg::FIELD_W-1:0] o_second_rate
);

    crm_pkg::t_state r_state, n_state;

    // configuration
    logic [crm_pkg::CNT_W-1:0] r_max_interval;

    // previous snapshot per channel
    logic                      r_last_avail [2];
    logic [crm_pkg::CNT_W-1:0] r_last_first [2];
    logic [crm_pkg::CNT_W-1:0] r_last_second [2];
    logic [crm_pkg::CNT_W-1:0] r_last_time [2];
    logic [crm_pkg::CNT_W-1:0] r_last_id [2];

    // current request
    logic                      r_kind;
    logic                      r_avail;
    logic [crm_pkg::CNT_W-1:0] r_first;
    logic [crm_pkg::CNT_W-1:0] r_second;
    logic [crm_pkg::CNT_W-1:0] r_time;
    logic [crm_pkg::CNT_W-1:0] r_id;
    logic [crm_pkg::CNT_W-1:0] r_el;
    logic [crm_pkg::CNT_W-1:0] r_d1;
    logic [crm_pkg::CNT_W-1:0] r_d2;
    logic                      r_bad;
    logic [crm_pkg::FIELD_W-1:0] r_rate1;
    logic [crm_pkg::FIELD_W-1:0] r_rate2;

    // output register
    logic                        r_out_valid;
    logic                        r_o_channel;
    logic                        r_o_baseline;
    logic                        r_o_rate_valid;
    logic [crm_pkg::FIELD_W-1:0] r_o_first;
    logic [crm_pkg::FIELD_W-1:0] r_o_second;

    logic                      accept;
    logic                      out_load;
    logic                      form_rate;
    logic [crm_pkg::CNT_W-1:0] sub_a;
    logic [crm_pkg::CNT_W-1:0] sub_b;
    logic [crm_pkg::CNT_W:0]   sub_r;
    logic                      sub_borrow;
    logic                      el_bad;
    logic                      unit_start;
    logic                      unit_done;
    logic [crm_pkg::CNT_W-1:0] unit_delta;
    logic [crm_pkg::FIELD_W-1:0] unit_rate;

    assign accept    = i_in_valid && !o_in_stall;
    assign out_load  = !r_out_valid || !i_out_stall;
    assign form_rate = r_avail && !r_bad;

    // shared subtractor: elapsed time, both deltas, then limit minus elapsed
    always_comb begin
        sub_a = '0;
        sub_b = '0;
        unique case (r_state)
            crm_pkg::S_EL: begin
                sub_a = r_time;
                sub_b = r_last_time[r_kind];
            end
            crm_pkg::S_DF: begin
                sub_a = r_first;
                sub_b = r_last_first[r_kind];
            end
            crm_pkg::S_DS: begin
                sub_a = r_second;
                sub_b = r_last_second[r_kind];
            end
            crm_pkg::S_LIM: begin
                sub_a = r_max_interval;
                sub_b = r_el;
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_r      = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_r[crm_pkg::CNT_W];
    assign el_bad     = sub_borrow || (sub_r[crm_pkg::CNT_W-1:0] == '0) ||
                        (r_id != r_last_id[r_kind]) || !r_last_avail[r_kind];

    // rate unit, first delta then second, both over the elapsed time
    assign unit_delta = (r_state == crm_pkg::S_R2_GO || r_state == crm_pkg::S_R2_WAIT)
                      ? r_d2 : r_d1;

    crm_rate_unit u_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (unit_start),
        .i_delta (unit_delta),
        .i_den   (r_el),
        .o_done  (unit_done),
        .o_rate  (unit_rate)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crm_pkg::S_IDLE:    if (accept) n_state = crm_pkg::S_EL;
            crm_pkg::S_EL:      n_state = crm_pkg::S_DF;
            crm_pkg::S_DF:      n_state = crm_pkg::S_DS;
            crm_pkg::S_DS:      n_state = crm_pkg::S_LIM;
            crm_pkg::S_LIM: begin
                n_state = (r_avail && !r_bad && !sub_borrow) ? crm_pkg::S_R1_GO
                                                             : crm_pkg::S_DONE;
            end
            crm_pkg::S_R1_GO:   n_state = crm_pkg::S_R1_WAIT;
            crm_pkg::S_R1_WAIT: if (unit_done) n_state = crm_pkg::S_R2_GO;
            crm_pkg::S_R2_GO:   n_state = crm_pkg::S_R2_WAIT;
            crm_pkg::S_R2_WAIT: if (unit_done) n_state = crm_pkg::S_DONE;
            crm_pkg::S_DONE:    if (out_load) n_state = crm_pkg::S_IDLE;
            default:            n_state = crm_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        unit_start = 1'b0;
        unique case (r_state)
            crm_pkg::S_IDLE:  o_in_stall = 1'b0;
            crm_pkg::S_R1_GO,
            crm_pkg::S_R2_GO: unit_start = 1'b1;
            default: begin
                o_in_stall = 1'b1;
                unit_start = 1'b0;
            end
        endcase
    end

    // state, configuration and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= crm_pkg::S_IDLE;
            r_max_interval  <= crm_pkg::MAX_INTERVAL_RESET;
            r_last_avail[0] <= 1'b0;
            r_last_avail[1] <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_interval <= i_cfg_data;
            end
            if (r_state == crm_pkg::S_DONE && out_load) begin
                r_last_avail[r_kind] <= r_avail;
                r_out_valid          <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            crm_pkg::S_IDLE: begin
                if (accept) begin
                    r_kind   <= i_kind;
                    r_avail  <= i_available;
                    r_first  <= i_first_count;
                    r_second <= i_second_count;
                    r_time   <= i_capture_time;
                    r_id     <= i_source_id;
                end
            end
            crm_pkg::S_EL: begin
                r_el  <= sub_r[crm_pkg::CNT_W-1:0];
                r_bad <= el_bad;
            end
            crm_pkg::S_DF: begin
                r_d1  <= sub_r[crm_pkg::CNT_W-1:0];
                r_bad <= r_bad || sub_borrow;
            end
            crm_pkg::S_DS: begin
                r_d2  <= sub_r[crm_pkg::CNT_W-1:0];
                r_bad <= r_bad || sub_borrow;
            end
            crm_pkg::S_LIM: begin
                r_bad <= r_bad || sub_borrow;
            end
            crm_pkg::S_R1_WAIT: begin
                if (unit_done) r_rate1 <= unit_rate;
            end
            crm_pkg::S_R2_WAIT: begin
                if (unit_done) r_rate2 <= unit_rate;
            end
            crm_pkg::S_DONE: begin
                if (out_load) begin
                    r_last_first[r_kind]  <= r_first;
                    r_last_second[r_kind] <= r_second;
                    r_last_time[r_kind]   <= r_time;
                    r_last_id[r_kind]     <= r_id;
                    r_o_channel           <= r_kind;
                    r_o_baseline          <= r_avail && r_bad;
                    r_o_rate_valid        <= form_rate;
                    r_o_first             <= form_rate ? r_rate1 : '0;
                    r_o_second            <= form_rate ? r_rate2 : '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_channel        = r_o_channel;
    assign o_needs_baseline = r_o_baseline;
    assign o_rate_valid     = r_o_rate_valid;
    assign o_first_rate     = r_o_first;
    assign o_second_rate    = r_o_second;

endmodule

// ===== sv/crm_checker.sv =====
// crm_checker: port-level checks on the counter pair rate meter
// bound to counter_pair_rate_meter_top; depends on crm_pkg

module crm_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_stall,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic                        o_channel,
    input  logic                        o_needs_baseline,
    input  logic                        o_rate_valid,
    input  logic [crm_pkg::FIELD_W-1:0] o_first_rate,
    input  logic [crm_pkg::FIELD_W-1:0] o_second_rate
);

    // a formed rate never asks for a new baseline
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_rate_valid && o_needs_baseline))
        else $error("rate_valid and needs_baseline both set");

    // rates read zero when none was formed
    a_rates_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_rate_valid) |-> (o_first_rate == '0 && o_second_rate == '0))
        else $error("nonzero rate without rate_valid");

    // the block is busy for at least the cycle after taking a request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a request");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_channel) && $stable(o_first_rate) &&
         $stable(o_second_rate) && $stable(o_rate_valid)))
        else $error("stalled result changed");

endmodule

bind counter_pair_rate_meter_top crm_checker u_crm_checker (.*);

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for counter_pair_rate_meter_top
// keeps its own per-channel snapshot store and rate arithmetic to predict every result
// depends on crm_pkg and counter_pair_rate_meter_top

module tb_top;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 700;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic                      kind;
        logic                      available;
        logic [crm_pkg::CNT_W-1:0] first_count;
        logic [crm_pkg::CNT_W-1:0] second_count;
        logic [crm_pkg::CNT_W-1:0] capture_time;
        logic [crm_pkg::CNT_W-1:0] source_id;
    } t_snapshot;

    typedef struct packed {
        logic                        channel;
        logic                        needs_baseline;
        logic                        rate_valid;
        logic [crm_pkg::FIELD_W-1:0] first_rate;
        logic [crm_pkg::FIELD_W-1:0] second_rate;
    } t_rate_report;

    // clock, reset and block inputs, all known from time zero
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [crm_pkg::CNT_W-1:0]   i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        i_kind = 1'b0;
    logic                        i_available = 1'b0;
    logic [crm_pkg::CNT_W-1:0]   i_first_count = '0;
    logic [crm_pkg::CNT_W-1:0]   i_second_count = '0;
    logic [crm_pkg::CNT_W-1:0]   i_capture_time = '0;
    logic [crm_pkg::CNT_W-1:0]   i_source_id = '0;
    logic                        i_out_stall = 1'b0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic                        o_channel;
    logic                        o_needs_baseline;
    logic                        o_rate_valid;
    logic [crm_pkg::FIELD_W-1:0] o_first_rate;
    logic [crm_pkg::FIELD_W-1:0] o_second_rate;

    // predictor state: interval limit and last snapshot per channel
    logic [crm_pkg::CNT_W-1:0] interval_limit = crm_pkg::MAX_INTERVAL_RESET;
    logic                      prev_avail [2] = '{1'b0, 1'b0};
    logic [crm_pkg::CNT_W-1:0] prev_first [2] = '{'0, '0};
    logic [crm_pkg::CNT_W-1:0] prev_second [2] = '{'0, '0};
    logic [crm_pkg::CNT_W-1:0] prev_time [2] = '{'0, '0};
    logic [crm_pkg::CNT_W-1:0] prev_id [2] = '{'0, '0};

    // stimulus side view of the last snapshot per channel, used to build sequences
    logic                      gen_avail [2] = '{1'b0, 1'b0};
    logic [crm_pkg::CNT_W-1:0] gen_first [2] = '{'0, '0};
    logic [crm_pkg::CNT_W-1:0] gen_second [2] = '{'0, '0};
    logic [crm_pkg::CNT_W-1:0] gen_time [2] = '{'0, '0};
    logic [crm_pkg::CNT_W-1:0] gen_id [2] = '{'0, '0};

    t_snapshot    snapshot_q [$];
    t_rate_report expected_rates [$];
    t_rate_report want_rep;

    int in_idle_pct = 28;
    int out_idle_pct = 28;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;

    counter_pair_rate_meter_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_available      (i_available),
        .i_first_count    (i_first_count),
        .i_second_count   (i_second_count),
        .i_capture_time   (i_capture_time),
        .i_source_id      (i_source_id),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_channel        (o_channel),
        .o_needs_baseline (o_needs_baseline),
        .o_rate_valid     (o_rate_valid),
        .o_first_rate     (o_first_rate),
        .o_second_rate    (o_second_rate)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [crm_pkg::CNT_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // floor(delta * ticks per second / elapsed), clipped to the rate width
    function automatic logic [crm_pkg::FIELD_W-1:0] bytes_per_sec(
        logic [crm_pkg::CNT_W-1:0] delta, logic [crm_pkg::CNT_W-1:0] elapsed);
        logic [127:0] num;
        logic [127:0] quot;
        logic [127:0] ceiling;
        num = 128'(delta) * 128'(crm_pkg::TICKS_PER_SECOND);
        quot = num / 128'(elapsed);
        ceiling = (crm_pkg::RATE_WIDTH >= 64) ? 128'(64'hFFFF_FFFF_FFFF_FFFF)
                                              : (128'd1 << crm_pkg::RATE_WIDTH) - 128'd1;
        if (quot > ceiling)
            quot = ceiling;
        return crm_pkg::FIELD_W'(quot);
    endfunction

    // one snapshot through the meter: checks against the stored one, then replaces it
    function automatic t_rate_report meter_step(t_snapshot s);
        t_rate_report r;
        logic [crm_pkg::CNT_W-1:0] gap;
        int c;
        c = int'(s.kind);
        r = '0;
        r.channel = s.kind;
        gap = s.capture_time - prev_time[c];
        if (s.available) begin
            if (!prev_avail[c] || s.source_id != prev_id[c] ||
                s.first_count < prev_first[c] || s.second_count < prev_second[c] ||
                s.capture_time <= prev_time[c] || gap > interval_limit) begin
                r.needs_baseline = 1'b1;
            end else begin
                r.rate_valid = 1'b1;
                r.first_rate = bytes_per_sec(s.first_count - prev_first[c], gap);
                r.second_rate = bytes_per_sec(s.second_count - prev_second[c], gap);
            end
        end
        prev_avail[c] = s.available;
        prev_first[c] = s.first_count;
        prev_second[c] = s.second_count;
        prev_time[c] = s.capture_time;
        prev_id[c] = s.source_id;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [crm_pkg::CNT_W-1:0] got,
                                   logic [crm_pkg::CNT_W-1:0] want);
        $display("mismatch %s: got 0x%0h want 0x%0h", what, got, want);
        mismatches++;
    endtask

    // snapshot source: presents queued requests, idles at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_rates.push_back(meter_step({i_kind, i_available, i_first_count,
                    i_second_count, i_capture_time, i_source_id}));
            if (!i_in_valid || !o_in_stall) begin
                if (snapshot_q.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
                    t_snapshot nxt;
                    nxt = snapshot_q.pop_front();
                    i_kind <= nxt.kind;
                    i_available <= nxt.available;
                    i_first_count <= nxt.first_count;
                    i_second_count <= nxt.second_count;
                    i_capture_time <= nxt.capture_time;
                    i_source_id <= nxt.source_id;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result sink stall: random, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
        end
    end

    // result check against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_rates.size() == 0) begin
                report_mismatch("result with nothing expected",
                                crm_pkg::CNT_W'(o_channel), '0);
            end else begin
                want_rep = expected_rates.pop_front();
                if (o_channel !== want_rep.channel)
                    report_mismatch("channel", crm_pkg::CNT_W'(o_channel),
                                    crm_pkg::CNT_W'(want_rep.channel));
                if (o_needs_baseline !== want_rep.needs_baseline)
                    report_mismatch("needs_baseline", crm_pkg::CNT_W'(o_needs_baseline),
                                    crm_pkg::CNT_W'(want_rep.needs_baseline));
                if (o_rate_valid !== want_rep.rate_valid)
                    report_mismatch("rate_valid", crm_pkg::CNT_W'(o_rate_valid),
                                    crm_pkg::CNT_W'(want_rep.rate_valid));
                if (o_first_rate !== want_rep.first_rate)
                    report_mismatch("first_rate", crm_pkg::CNT_W'(o_first_rate),
                                    crm_pkg::CNT_W'(want_rep.first_rate));
                if (o_second_rate !== want_rep.second_rate)
                    report_mismatch("second_rate", crm_pkg::CNT_W'(o_second_rate),
                                    crm_pkg::CNT_W'(want_rep.second_rate));
            end
        end
    end

    // watchdog on cycles without any request moving
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[counter_pair_rate_meter_top] ERROR");
            $finish;
        end
    end

    task automatic queue_snapshot(bit ch, bit avail, logic [crm_pkg::CNT_W-1:0] f,
                                  logic [crm_pkg::CNT_W-1:0] s,
                                  logic [crm_pkg::CNT_W-1:0] t,
                                  logic [crm_pkg::CNT_W-1:0] id);
        snapshot_q.push_back({ch, avail, f, s, t, id});
        gen_avail[ch] = avail;
        gen_first[ch] = f;
        gen_second[ch] = s;
        gen_time[ch] = t;
        gen_id[ch] = id;
    endtask

    // next available snapshot on the same source, counters and time moved on
    task automatic follow_on(bit ch, logic [crm_pkg::CNT_W-1:0] df,
                             logic [crm_pkg::CNT_W-1:0] ds,
                             logic [crm_pkg::CNT_W-1:0] gap);
        queue_snapshot(ch, 1'b1, gen_first[ch] + df, gen_second[ch] + ds,
                       gen_time[ch] + gap, gen_id[ch]);
    endtask

    function automatic logic [crm_pkg::CNT_W-1:0] pick_delta();
        case ($urandom_range(0, 9))
            0:          return '0;
            1, 2, 3, 4: return crm_pkg::CNT_W'($urandom_range(0, 5000));
            5, 6, 7:    return crm_pkg::CNT_W'($urandom);
            8:          return rand64() >> $urandom_range(0, 63);
            default:    return rand64();
        endcase
    endfunction

    // elapsed ticks within the current limit when it is nonzero, biased to short gaps and the edge
    function automatic logic [crm_pkg::CNT_W-1:0] pick_gap();
        logic [crm_pkg::CNT_W-1:0] g;
        if (interval_limit == '0)
            return crm_pkg::CNT_W'($urandom_range(1, 20));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: g = crm_pkg::CNT_W'($urandom_range(1, 20));
            4, 5, 6, 7: g = 1 + (crm_pkg::CNT_W'($urandom) % interval_limit);
            8:          g = interval_limit;
            default:    g = 1 + (rand64() % interval_limit);
        endcase
        if (g > interval_limit)
            g = interval_limit;
        return g;
    endfunction

    // mostly well-formed sequences with random content, some broken, some noise
    task automatic random_snapshots(int count);
        bit ch;
        logic [crm_pkg::CNT_W-1:0] d;
        int pick;
        for (int n = 0; n < count; n++) begin
            ch = $urandom_range(0, 1);
            pick = $urandom_range(0, 99);
            d = crm_pkg::CNT_W'($urandom_range(1, 9));
            if (pick < 65) begin
                follow_on(ch, pick_delta(), pick_delta(), pick_gap());
            end else if (pick < 73) begin
                queue_snapshot(ch, 1'b1, rand64() >> $urandom_range(0, 63),
                               rand64() >> $urandom_range(0, 63),
                               rand64() >> $urandom_range(0, 63), rand64());
            end else if (pick < 80) begin
                queue_snapshot(ch, 1'b0, rand64(), rand64(), rand64(), rand64());
            end else if (pick < 88) begin
                case ($urandom_range(0, 4))
                    0: queue_snapshot(ch, 1'b1, gen_first[ch], gen_second[ch],
                                      gen_time[ch] + 1, gen_id[ch] ^ rand64() ^ 1);
                    1: follow_on(ch, -d, pick_delta(), pick_gap());
                    2: follow_on(ch, pick_delta(), -d, pick_gap());
                    3: follow_on(ch, pick_delta(), pick_delta(), -(d - 1));
                    default: follow_on(ch, pick_delta(), pick_delta(), interval_limit + d);
                endcase
            end else begin
                queue_snapshot(ch, 1'($urandom), rand64(), rand64(), rand64(), rand64());
            end
        end
    endtask

    // block idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        while (snapshot_q.size() != 0 || i_in_valid || expected_rates.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_limit(logic [crm_pkg::CNT_W-1:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        interval_limit = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset limit: unavailable, first baseline, rates, limit edge, each reject reason
        queue_snapshot(0, 1'b0, rand64(), rand64(), rand64(), rand64());
        queue_snapshot(0, 1'b1, 64'd1000, 64'd2000, 64'd500, 64'd7);
        follow_on(0, 64'd1000, 64'd0, 64'd10);
        follow_on(0, 64'd28147497, 64'd28147498, 64'd1);
        follow_on(0, 64'd1 << 40, 64'd3, crm_pkg::MAX_INTERVAL_RESET);
        follow_on(0, 64'd5, 64'd5, crm_pkg::MAX_INTERVAL_RESET + 1);
        queue_snapshot(0, 1'b1, gen_first[0] + 1, gen_second[0] + 1, gen_time[0] + 1,
                       gen_id[0] + 1);
        follow_on(0, '1, 64'd0, 64'd1);
        follow_on(0, 64'd0, '1, 64'd1);
        follow_on(0, 64'd1, 64'd1, 64'd0);
        follow_on(0, 64'd1, 64'd1, '1);
        follow_on(0, 64'd12345, 64'd678, 64'd1000);
        // disk channel: counter extremes, wide saturation, baseline after unavailable
        queue_snapshot(1, 1'b1, '0, '0, '0, '1);
        queue_snapshot(1, 1'b1, '1, '1, 64'd1, '1);
        queue_snapshot(1, 1'b0, rand64(), rand64(), rand64(), rand64());
        queue_snapshot(1, 1'b1, 64'd100, 64'd100, '1 - 64'd50, 64'd42);
        follow_on(1, 64'd5, 64'd3, 64'd3);

        // smallest limit: gap of one passes, two fails
        write_limit(64'd1);
        follow_on(0, 64'd77, 64'd88, 64'd1);
        follow_on(0, 64'd1, 64'd1, 64'd2);

        // largest limit: whole time range as one gap
        write_limit('1);
        queue_snapshot(1, 1'b1, '0, '0, '0, 64'd9);
        follow_on(1, 64'd5, 64'd5, '1);

        // zero limit rejects every gap
        write_limit('0);
        follow_on(0, 64'd1, 64'd1, 64'd1);
        follow_on(0, 64'd1, 64'd1, 64'd1);

        // random phases across limit settings
        write_limit(crm_pkg::MAX_INTERVAL_RESET);
        random_snapshots(400);

        write_limit(crm_pkg::CNT_W'($urandom) | 64'd1);
        @(negedge i_clk);
        in_idle_pct = 0;
        out_idle_pct = 0;
        random_snapshots(350);
        wait_idle();
        in_idle_pct = 28;
        out_idle_pct = 28;

        write_limit(64'd1);
        random_snapshots(120);

        write_limit('1);
        random_snapshots(300);

        write_limit('0);
        random_snapshots(80);

        write_limit(rand64() | 64'd1);
        random_snapshots(150);

        // long sink hold-off while snapshots keep coming
        write_limit(crm_pkg::MAX_INTERVAL_RESET);
        random_snapshots(400);
        hold_req = 1'b1;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_rates.size() == 0)
            $display("[counter_pair_rate_meter_top] OK");
        else
            $display("[counter_pair_rate_meter_top] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/crm_pkg.sv
sv/crm_rate_unit.sv
sv/counter_pair_rate_meter_top.sv
sv/crm_checker.sv
dv/tb_top.sv
